FILE: design/tlvp_pkg.sv
// ----------------------------------------------------------------------------
// tlvp_pkg: shared types and constants of the TLV container parser
// Transfer structs, status and section codes, limits and the CRC-8 step.
// ----------------------------------------------------------------------------
package tlvp_pkg;

    // Section size limits
    localparam logic [15:0] MAX_BEHAVIOR_BYTES = 16'd256;
    localparam logic [15:0] MAX_DATA_BYTES     = 16'd256;
    localparam logic [15:0] MAX_STATE_BYTES    = 16'd256;
    localparam logic [15:0] CAPABILITY_BYTES   = 16'd32;

    // Output queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAG_BEH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAG_DATA = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAG_ST   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAG_CAP  = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_CRC     = 3'd2;
    localparam logic [2:0] ST_MAGIC   = 3'd3;
    localparam logic [2:0] ST_OVERRUN = 3'd4;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Section codes
    localparam logic [1:0] SEC_BEHAVIOR   = 2'd0;
    localparam logic [1:0] SEC_DATA       = 2'd1;
    localparam logic [1:0] SEC_STATE      = 2'd2;
    localparam logic [1:0] SEC_CAPABILITY = 2'd3;

    localparam logic [7:0] CRC_POLY = 8'h07;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  section;
        logic [7:0]  section_offset;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [7:0]  version_out;
        logic [7:0]  flags_out;
        logic [15:0] fuel_out;
        logic [7:0]  total_len_out;
        logic        last;
    } result_t;

    // Up to two results written into the output queue per accepted byte
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

    // CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: design/tlv_container_parser_crc8.sv
// ----------------------------------------------------------------------------
// tlv_container_parser_crc8: TLV message parser with CRC-8 header check
// Byte-wide parser that emits record payload bytes and one end status.
// ----------------------------------------------------------------------------
//  Channel   Handshake                     Payload
//  item      item_valid / item_ready       item   (in_byte, end_of_message)
//  result    result_valid / result_ready   result (kind ... last)
//  config    cfg_we, no wait               cfg_index, cfg_data
//
//  One byte is accepted per cycle while item_ready is high; the parse state is
//  updated and its results are written to the queue as the byte is accepted.
//  A byte can cause two results; the four-entry result queue drains one per
//  cycle while result_ready is high, so item_ready drops only below two free slots.
//  Reset (rst_n low, asynchronous) returns to the header phase with an empty
//  queue and default tag codes.
// ----------------------------------------------------------------------------
module tlv_container_parser_crc8 (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  tlvp_pkg::item_t                      item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output tlvp_pkg::result_t                    result,
    input  logic                                 cfg_we,
    input  logic [tlvp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tlvp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tlvp_pkg::*;

    cfg_write_t cfg;
    push_t      push;
    logic       room;
    logic       take;

    assign cfg.we     = cfg_we;
    assign cfg.index  = cfg_index;
    assign cfg.data   = cfg_data;
    assign item_ready = room;
    assign take       = item_valid && item_ready;

    tlvp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .cfg   (cfg),
        .push  (push)
    );

    tlvp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (result)
    );

endmodule

FILE: design/tlvp_parser.sv
// ----------------------------------------------------------------------------
// tlvp_parser: header and record state machine
// Updates the parse state on each accepted byte and forms its results.
// ----------------------------------------------------------------------------
module tlvp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  tlvp_pkg::item_t      item,
    input  tlvp_pkg::cfg_write_t cfg,
    output tlvp_pkg::push_t      push
);
    import tlvp_pkg::*;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_TAG     = 3'd1;
    localparam logic [2:0] PH_LEN_HI  = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_SKIP    = 3'd5;

    // Configuration
    logic [15:0] magic_value_reg;
    logic [7:0]  tag_behavior_reg, tag_data_reg, tag_state_reg, tag_capability_reg;

    // Message state
    logic [3:0]  header_count_reg, header_count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] magic_seen_reg, magic_seen_next;
    logic [7:0]  version_seen_reg, version_seen_next;
    logic [7:0]  flags_seen_reg, flags_seen_next;
    logic [15:0] fuel_seen_reg, fuel_seen_next;
    logic [7:0]  total_len_seen_reg, total_len_seen_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  record_tag_reg, record_tag_next;
    logic [15:0] record_length_reg, record_length_next;
    logic [15:0] bytes_remaining_reg, bytes_remaining_next;
    logic        record_accepted_reg, record_accepted_next;
    logic [1:0]  record_section_reg, record_section_next;
    logic [2:0]  error_code_reg, error_code_next;

    logic [7:0]  b;
    logic        eom;
    logic [15:0] len_new;
    logic [15:0] offset_full;
    logic [1:0]  sec_dec;
    logic        acc_dec;
    logic [2:0]  step_status;
    logic [2:0]  final_status;
    logic        pay_valid;
    result_t     pay_res;
    result_t     st_res;

    assign b           = item.in_byte;
    assign eom         = item.end_of_message;
    assign len_new     = {record_length_reg[15:8], b};
    assign offset_full = record_length_reg - bytes_remaining_reg;

    // Record acceptance, first matching tag wins
    always_comb
    begin
        sec_dec = SEC_BEHAVIOR;
        acc_dec = 1'b0;
        if (len_new != 16'd0)
        begin
            if (record_tag_reg == tag_behavior_reg)
            begin
                sec_dec = SEC_BEHAVIOR;
                acc_dec = (len_new <= MAX_BEHAVIOR_BYTES);
            end
            else if (record_tag_reg == tag_data_reg)
            begin
                sec_dec = SEC_DATA;
                acc_dec = (len_new <= MAX_DATA_BYTES);
            end
            else if (record_tag_reg == tag_state_reg)
            begin
                sec_dec = SEC_STATE;
                acc_dec = (len_new <= MAX_STATE_BYTES);
            end
            else if (record_tag_reg == tag_capability_reg)
            begin
                sec_dec = SEC_CAPABILITY;
                acc_dec = (len_new == CAPABILITY_BYTES);
            end
        end
    end

    always_comb
    begin
        header_count_next    = header_count_reg;
        crc_next             = crc_reg;
        magic_seen_next      = magic_seen_reg;
        version_seen_next    = version_seen_reg;
        flags_seen_next      = flags_seen_reg;
        fuel_seen_next       = fuel_seen_reg;
        total_len_seen_next  = total_len_seen_reg;
        phase_next           = phase_reg;
        record_tag_next      = record_tag_reg;
        record_length_next   = record_length_reg;
        bytes_remaining_next = bytes_remaining_reg;
        record_accepted_next = record_accepted_reg;
        record_section_next  = record_section_reg;
        error_code_next      = error_code_reg;
        step_status          = ST_OK;
        pay_valid            = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (header_count_reg < 4'd7)
                begin
                    crc_next = crc8_step(crc_reg, b);
                end
                case (header_count_reg)
                    4'd0:    magic_seen_next = {b, magic_seen_reg[7:0]};
                    4'd1:    magic_seen_next = {magic_seen_reg[15:8], b};
                    4'd2:    version_seen_next = b;
                    4'd3:    flags_seen_next = b;
                    4'd4:    fuel_seen_next = {b, fuel_seen_reg[7:0]};
                    4'd5:    fuel_seen_next = {fuel_seen_reg[15:8], b};
                    4'd6:    total_len_seen_next = b;
                    default: ;
                endcase
                header_count_next = (header_count_reg < 4'd8) ? header_count_reg + 4'd1 : 4'd8;
                if (header_count_reg >= 4'd7)
                begin
                    // CRC byte: check CRC first, then magic
                    if (crc_reg != b)
                    begin
                        error_code_next = ST_CRC;
                        phase_next      = PH_SKIP;
                    end
                    else if (magic_seen_reg != magic_value_reg)
                    begin
                        error_code_next = ST_MAGIC;
                        phase_next      = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
                else if (eom)
                begin
                    step_status = ST_SHORT;
                end
            end
            PH_TAG:
            begin
                record_tag_next = b;
                phase_next      = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                record_length_next = {b, 8'h00};
                phase_next         = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                record_length_next   = len_new;
                bytes_remaining_next = len_new;
                record_accepted_next = acc_dec;
                record_section_next  = sec_dec;
                if (len_new == 16'd0)
                begin
                    phase_next = PH_TAG;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                    if (eom)
                    begin
                        step_status = ST_OVERRUN;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                pay_valid            = record_accepted_reg;
                bytes_remaining_next = bytes_remaining_reg - 16'd1;
                if (bytes_remaining_next == 16'd0)
                begin
                    phase_next = PH_TAG;
                end
                else if (eom)
                begin
                    step_status = ST_OVERRUN;
                end
            end
            default: ;
        endcase

        final_status = (error_code_next != ST_OK) ? error_code_next : step_status;

        pay_res                = '0;
        pay_res.kind           = KIND_PAYLOAD;
        pay_res.section        = record_section_reg;
        pay_res.section_offset = offset_full[7:0];
        pay_res.payload_byte   = b;
        pay_res.last           = !eom;

        st_res        = '0;
        st_res.kind   = KIND_STATUS;
        st_res.status = final_status;
        st_res.last   = 1'b1;
        if (final_status != ST_SHORT)
        begin
            st_res.version_out   = version_seen_next;
            st_res.flags_out     = flags_seen_next;
            st_res.fuel_out      = fuel_seen_next;
            st_res.total_len_out = total_len_seen_next;
        end

        // End of message: clear back to the header phase
        if (eom)
        begin
            header_count_next    = 4'd0;
            crc_next             = 8'd0;
            magic_seen_next      = 16'd0;
            version_seen_next    = 8'd0;
            flags_seen_next      = 8'd0;
            fuel_seen_next       = 16'd0;
            total_len_seen_next  = 8'd0;
            phase_next           = PH_HEADER;
            record_tag_next      = 8'd0;
            record_length_next   = 16'd0;
            bytes_remaining_next = 16'd0;
            record_accepted_next = 1'b0;
            record_section_next  = SEC_BEHAVIOR;
            error_code_next      = ST_OK;
        end

        push = '0;
        if (take)
        begin
            if (pay_valid && eom)
            begin
                push.cnt    = 2'd2;
                push.first  = pay_res;
                push.second = st_res;
            end
            else if (pay_valid)
            begin
                push.cnt   = 2'd1;
                push.first = pay_res;
            end
            else if (eom)
            begin
                push.cnt   = 2'd1;
                push.first = st_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_value_reg    <= 16'd0;
            tag_behavior_reg   <= 8'd1;
            tag_data_reg       <= 8'd2;
            tag_state_reg      <= 8'd3;
            tag_capability_reg <= 8'd4;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                CFG_MAGIC:    magic_value_reg    <= cfg.data;
                CFG_TAG_BEH:  tag_behavior_reg   <= cfg.data[7:0];
                CFG_TAG_DATA: tag_data_reg       <= cfg.data[7:0];
                CFG_TAG_ST:   tag_state_reg      <= cfg.data[7:0];
                CFG_TAG_CAP:  tag_capability_reg <= cfg.data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg    <= 4'd0;
            crc_reg             <= 8'd0;
            magic_seen_reg      <= 16'd0;
            version_seen_reg    <= 8'd0;
            flags_seen_reg      <= 8'd0;
            fuel_seen_reg       <= 16'd0;
            total_len_seen_reg  <= 8'd0;
            phase_reg           <= PH_HEADER;
            record_tag_reg      <= 8'd0;
            record_length_reg   <= 16'd0;
            bytes_remaining_reg <= 16'd0;
            record_accepted_reg <= 1'b0;
            record_section_reg  <= SEC_BEHAVIOR;
            error_code_reg      <= ST_OK;
        end
        else if (take)
        begin
            header_count_reg    <= header_count_next;
            crc_reg             <= crc_next;
            magic_seen_reg      <= magic_seen_next;
            version_seen_reg    <= version_seen_next;
            flags_seen_reg      <= flags_seen_next;
            fuel_seen_reg       <= fuel_seen_next;
            total_len_seen_reg  <= total_len_seen_next;
            phase_reg           <= phase_next;
            record_tag_reg      <= record_tag_next;
            record_length_reg   <= record_length_next;
            bytes_remaining_reg <= bytes_remaining_next;
            record_accepted_reg <= record_accepted_next;
            record_section_reg  <= record_section_next;
            error_code_reg      <= error_code_next;
        end
    end

    a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> bytes_remaining_reg != 16'd0)
        else $error("payload phase with no bytes remaining");

    a_header_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HEADER) |-> header_count_reg == 4'd8 || header_count_reg == 4'd0)
        else $error("header count inconsistent with parse phase");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> push.first.kind == KIND_PAYLOAD && !push.first.last
                             && push.second.kind == KIND_STATUS && push.second.last)
        else $error("two results not ordered payload then status");

    a_error_skips: assert property (@(posedge clk) disable iff (!rst_n)
        error_code_reg != ST_OK |-> phase_reg == PH_SKIP)
        else $error("header error without skip phase");

endmodule

FILE: design/tlvp_out_fifo.sv
// ----------------------------------------------------------------------------
// tlvp_out_fifo: result queue
// Takes up to two results per cycle and hands out one per transfer.
// ----------------------------------------------------------------------------
module tlvp_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  tlvp_pkg::push_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output tlvp_pkg::result_t out_data
);
    import tlvp_pkg::*;

    result_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wptr_reg, rptr_reg;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic [FIFO_AW-1:0]   wptr_plus1;
    logic                 pop;

    assign wptr_plus1 = wptr_reg + FIFO_AW'(1);
    assign out_valid  = (count_reg != '0);
    assign out_data   = entry_reg[rptr_reg];
    assign pop        = out_valid && out_ready;
    // Accept a byte only with space for its worst case of two results
    assign room       = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign count_next = count_reg + FIFO_CW'(push.cnt) - FIFO_CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entry_reg[wptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            entry_reg[wptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_reg + FIFO_AW'(push.cnt);
            rptr_reg  <= rptr_reg + FIFO_AW'(pop);
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> room)
        else $error("result written without room");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd2 && !pop) |=> count_reg == $past(count_reg) + FIFO_CW'(2))
        else $error("result queue count lost a write");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tlv_container_parser_crc8
// Feeds whole messages byte by byte with random gaps and output stalls,
// predicts every payload and status result, and checks each transfer.
// ----------------------------------------------------------------------------
module testbench;

    import tlvp_pkg::*;

    typedef enum logic [2:0] {
        AT_HEADER,
        AT_TAG,
        AT_LEN_HI,
        AT_LEN_LO,
        AT_PAYLOAD,
        AT_DISCARD
    } parse_phase_e;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    item_t                  item = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    tlv_container_parser_crc8 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Register copies
    logic [15:0] cur_magic = 16'd0;
    logic [7:0]  cur_tag_beh = 8'd1;
    logic [7:0]  cur_tag_data = 8'd2;
    logic [7:0]  cur_tag_state = 8'd3;
    logic [7:0]  cur_tag_cap = 8'd4;

    // Parser state
    logic [3:0]   hdr_pos;
    logic [7:0]   hdr_crc;
    logic [15:0]  got_magic;
    logic [7:0]   got_version;
    logic [7:0]   got_flags;
    logic [15:0]  got_fuel;
    logic [7:0]   got_total_len;
    parse_phase_e phase;
    logic [7:0]   rec_tag;
    logic [15:0]  rec_len;
    logic [15:0]  rec_left;
    logic         rec_keep;
    logic [1:0]   rec_section;
    logic [2:0]   msg_error;

    item_t       byte_stream[$];
    result_t     due_results[$];
    logic [7:0]  msg_bytes[$];
    int          bytes_posted = 0;
    int          mismatch_count = 0;

    logic item_taken = 1'b0;
    logic result_taken = 1'b0;
    int   send_gap = 0;
    int   send_calm = 0;
    int   recv_gap = 0;
    int   recv_calm = 0;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        logic       fb;
        acc = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = acc[7] ^ b[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    function automatic void restart_message();
        hdr_pos = 4'd0;
        hdr_crc = 8'd0;
        got_magic = 16'd0;
        got_version = 8'd0;
        got_flags = 8'd0;
        got_fuel = 16'd0;
        got_total_len = 8'd0;
        phase = AT_HEADER;
        rec_tag = 8'd0;
        rec_len = 16'd0;
        rec_left = 16'd0;
        rec_keep = 1'b0;
        rec_section = SEC_BEHAVIOR;
        msg_error = ST_OK;
    endfunction

    // Advance the parser by one byte and queue the results it causes
    function automatic void parse_byte(input item_t it);
        result_t     outs[2];
        int          n;
        logic [2:0]  st;
        logic [15:0] off;
        n = 0;
        st = ST_OK;
        case (phase)
            AT_HEADER:
            begin
                if (hdr_pos < 4'd7)
                    hdr_crc = crc8_next(hdr_crc, it.in_byte);
                case (hdr_pos)
                    4'd0: got_magic[15:8] = it.in_byte;
                    4'd1: got_magic[7:0] = it.in_byte;
                    4'd2: got_version = it.in_byte;
                    4'd3: got_flags = it.in_byte;
                    4'd4: got_fuel[15:8] = it.in_byte;
                    4'd5: got_fuel[7:0] = it.in_byte;
                    4'd6: got_total_len = it.in_byte;
                    default: ;
                endcase
                if (hdr_pos >= 4'd7)
                begin
                    if (hdr_crc != it.in_byte)
                    begin
                        msg_error = ST_CRC;
                        phase = AT_DISCARD;
                    end
                    else if (got_magic != cur_magic)
                    begin
                        msg_error = ST_MAGIC;
                        phase = AT_DISCARD;
                    end
                    else
                        phase = AT_TAG;
                end
                else if (it.end_of_message)
                    st = ST_SHORT;
                hdr_pos = hdr_pos + 4'd1;
            end
            AT_TAG:
            begin
                rec_tag = it.in_byte;
                phase = AT_LEN_HI;
            end
            AT_LEN_HI:
            begin
                rec_len = {it.in_byte, 8'h00};
                phase = AT_LEN_LO;
            end
            AT_LEN_LO:
            begin
                rec_len[7:0] = it.in_byte;
                rec_left = rec_len;
                // First matching tag wins; the decision holds for the whole record
                rec_keep = 1'b0;
                rec_section = SEC_BEHAVIOR;
                if (rec_len != 16'd0)
                begin
                    if (rec_tag == cur_tag_beh)
                    begin
                        rec_section = SEC_BEHAVIOR;
                        rec_keep = (rec_len <= MAX_BEHAVIOR_BYTES);
                    end
                    else if (rec_tag == cur_tag_data)
                    begin
                        rec_section = SEC_DATA;
                        rec_keep = (rec_len <= MAX_DATA_BYTES);
                    end
                    else if (rec_tag == cur_tag_state)
                    begin
                        rec_section = SEC_STATE;
                        rec_keep = (rec_len <= MAX_STATE_BYTES);
                    end
                    else if (rec_tag == cur_tag_cap)
                    begin
                        rec_section = SEC_CAPABILITY;
                        rec_keep = (rec_len == CAPABILITY_BYTES);
                    end
                end
                if (rec_len == 16'd0)
                    phase = AT_TAG;
                else
                begin
                    phase = AT_PAYLOAD;
                    if (it.end_of_message)
                        st = ST_OVERRUN;
                end
            end
            AT_PAYLOAD:
            begin
                if (rec_keep)
                begin
                    off = rec_len - rec_left;
                    outs[n] = '0;
                    outs[n].kind = KIND_PAYLOAD;
                    outs[n].section = rec_section;
                    outs[n].section_offset = off[7:0];
                    outs[n].payload_byte = it.in_byte;
                    n++;
                end
                rec_left = rec_left - 16'd1;
                if (rec_left == 16'd0)
                    phase = AT_TAG;
                else if (it.end_of_message)
                    st = ST_OVERRUN;
            end
            default: ;
        endcase

        if (it.end_of_message)
        begin
            if (msg_error != ST_OK)
                st = msg_error;
            outs[n] = '0;
            outs[n].kind = KIND_STATUS;
            outs[n].status = st;
            if (st != ST_SHORT)
            begin
                outs[n].version_out = got_version;
                outs[n].flags_out = got_flags;
                outs[n].fuel_out = got_fuel;
                outs[n].total_len_out = got_total_len;
            end
            n++;
            restart_message();
        end

        if (n > 0)
            outs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            due_results.push_back(outs[i]);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Wait count for one transfer, with calm stretches of no idling
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 17);
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_tag();
        case ($urandom_range(0, 9))
            0, 1: return cur_tag_beh;
            2, 3: return cur_tag_data;
            4, 5: return cur_tag_state;
            6, 7: return cur_tag_cap;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 16'd0;
        if (r < 16)
            return CAPABILITY_BYTES;
        if (r < 20)
            return ($urandom_range(0, 1) == 0) ? CAPABILITY_BYTES - 16'd1
                                               : CAPABILITY_BYTES + 16'd1;
        if (r < 26)
            return 16'($urandom_range(41, 65535));
        return 16'($urandom_range(1, 12));
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        msg_bytes.push_back(b);
    endfunction

    function automatic void put_header(input logic [15:0] magic, input logic [7:0] version,
                                       input logic [7:0] flags, input logic [15:0] fuel,
                                       input logic [7:0] msg_len_byte, input logic bad_crc);
        logic [7:0] hdr[7];
        logic [7:0] crc;
        hdr = '{magic[15:8], magic[7:0], version, flags, fuel[15:8], fuel[7:0], msg_len_byte};
        crc = 8'd0;
        foreach (hdr[i])
        begin
            crc = crc8_next(crc, hdr[i]);
            add_byte(hdr[i]);
        end
        if (bad_crc)
            crc = crc ^ 8'($urandom_range(1, 255));
        add_byte(crc);
    endfunction

    function automatic void post_message(input logic close);
        item_t it;
        foreach (msg_bytes[i])
        begin
            it.in_byte = msg_bytes[i];
            it.end_of_message = close && (i == msg_bytes.size() - 1);
            byte_stream.push_back(it);
        end
        bytes_posted += msg_bytes.size();
        msg_bytes.delete();
    endfunction

    function automatic void build_message();
        int          form;
        int          nrec;
        logic [7:0]  tag;
        logic [15:0] len;
        logic [15:0] magic;
        form = $urandom_range(0, 15);
        if (form == 0)
        begin
            repeat ($urandom_range(1, 7)) add_byte(rand_byte());
            post_message(1'b1);
            return;
        end
        if (form == 1)
        begin
            repeat ($urandom_range(8, 20)) add_byte(rand_byte());
            post_message(1'b1);
            return;
        end
        magic = cur_magic;
        if ($urandom_range(0, 9) == 0)
            magic = magic ^ 16'($urandom_range(1, 65535));
        put_header(magic, rand_byte(), rand_byte(), {rand_byte(), rand_byte()}, rand_byte(),
                   $urandom_range(0, 9) == 0);
        nrec = $urandom_range(0, 4);
        for (int i = 0; i < nrec; i++)
        begin
            tag = pick_tag();
            len = pick_len();
            add_byte(tag);
            add_byte(len[15:8]);
            add_byte(len[7:0]);
            // Long records are cut short by the end of the message
            if (len > 16'd40)
            begin
                repeat ($urandom_range(1, 6)) add_byte(rand_byte());
                post_message(1'b1);
                return;
            end
            repeat (len) add_byte(rand_byte());
        end
        case ($urandom_range(0, 7))
            0: add_byte(pick_tag());
            1:
            begin
                add_byte(pick_tag());
                add_byte(rand_byte());
            end
            2:
            begin
                len = 16'($urandom_range(1, 12));
                add_byte(pick_tag());
                add_byte(len[15:8]);
                add_byte(len[7:0]);
                repeat ($urandom_range(0, int'(len) - 1)) add_byte(rand_byte());
            end
            default: ;
        endcase
        post_message(1'b1);
    endfunction

    task automatic random_traffic(input int n);
        int target;
        target = bytes_posted + n;
        while (bytes_posted < target)
            build_message();
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MAGIC:    cur_magic = val;
            CFG_TAG_BEH:  cur_tag_beh = val[7:0];
            CFG_TAG_DATA: cur_tag_data = val[7:0];
            CFG_TAG_ST:   cur_tag_state = val[7:0];
            CFG_TAG_CAP:  cur_tag_cap = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every byte is sent and every result is back, then let the pipe settle
    task automatic wait_drain();
        while (byte_stream.size() != 0 || item_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Driver: present bytes and output readiness on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_taken)
            begin
                if (send_gap > 0)
                begin
                    item_valid <= 1'b0;
                    send_gap--;
                end
                else if (byte_stream.size() != 0)
                begin
                    item <= byte_stream.pop_front();
                    item_valid <= 1'b1;
                    send_gap = draw_wait(send_calm);
                end
                else
                    item_valid <= 1'b0;
            end
            if (result_taken)
            begin
                recv_gap = draw_wait(recv_calm);
            end
            if (recv_gap > 0)
            begin
                result_ready <= 1'b0;
                recv_gap--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Monitor: check result transfers, then predict from byte transfers
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            item_taken = item_valid && item_ready;
            result_taken = result_valid && result_ready;
            if (result_valid && result_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d status %0d payload 0x%0h",
                           result.kind, result.status, result.payload_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(result.kind));
                    check_field("section", 16'(want.section), 16'(result.section));
                    check_field("section_offset", 16'(want.section_offset),
                                16'(result.section_offset));
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(result.payload_byte));
                    check_field("status", 16'(want.status), 16'(result.status));
                    check_field("version_out", 16'(want.version_out),
                                16'(result.version_out));
                    check_field("flags_out", 16'(want.flags_out), 16'(result.flags_out));
                    check_field("fuel_out", want.fuel_out, result.fuel_out);
                    check_field("total_len_out", 16'(want.total_len_out),
                                16'(result.total_len_out));
                    check_field("last", 16'(want.last), 16'(result.last));
                end
            end
            if (item_valid && item_ready)
            begin
                parse_byte(item);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("** tlv_container_parser_crc8: FAILED **");
        $finish;
    end

    initial
    begin
        restart_message();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Register values out of reset
        add_byte(8'hFF);
        post_message(1'b1);

        put_header(16'h0000, 8'hFF, 8'h00, 16'hFFFF, 8'h00, 1'b0);
        add_byte(8'h01); add_byte(8'h00); add_byte(8'h01); add_byte(8'hFF);
        add_byte(8'h02); add_byte(8'h00); add_byte(8'h00);
        add_byte(8'h09); add_byte(8'h00); add_byte(8'h02); add_byte(8'hAA); add_byte(8'h55);
        add_byte(8'h03); add_byte(8'h00); add_byte(8'h02); add_byte(8'h00); add_byte(8'hFF);
        add_byte(8'h04);
        post_message(1'b1);

        put_header(16'h0000, 8'h00, 8'hFF, 16'h0000, 8'hFF, 1'b1);
        add_byte(8'h01); add_byte(8'h00); add_byte(8'h01); add_byte(8'h12);
        post_message(1'b1);

        put_header(16'h8001, 8'h5A, 8'hA5, 16'h1234, 8'h40, 1'b0);
        post_message(1'b1);

        put_header(16'h0000, 8'h01, 8'h02, 16'h0304, 8'h05, 1'b0);
        add_byte(8'h03); add_byte(8'h00);
        post_message(1'b1);

        put_header(16'h0000, 8'h10, 8'h20, 16'h8000, 8'h7F, 1'b0);
        add_byte(8'h04); add_byte(8'h00); add_byte(8'h20);
        repeat (32) add_byte(rand_byte());
        add_byte(8'h02); add_byte(8'h00); add_byte(8'h05); add_byte(8'h11); add_byte(8'h22);
        post_message(1'b1);
        wait_drain();

        // Extreme register values, a full-size record and an oversize one
        set_reg(CFG_MAGIC, 16'hFFFF);
        set_reg(CFG_TAG_BEH, 16'h00FF);
        set_reg(CFG_TAG_DATA, 16'hFF00);
        set_reg(CFG_TAG_ST, 16'h0080);
        set_reg(CFG_TAG_CAP, 16'hA57F);
        put_header(cur_magic, rand_byte(), rand_byte(), {rand_byte(), rand_byte()},
                   rand_byte(), 1'b0);
        add_byte(cur_tag_data); add_byte(8'h01); add_byte(8'h00);
        repeat (256) add_byte(rand_byte());
        add_byte(cur_tag_beh); add_byte(8'h01); add_byte(8'h01);
        repeat (5) add_byte(rand_byte());
        post_message(1'b1);
        random_traffic(150);
        wait_drain();

        // All tags alike: the behavior section takes every match
        set_reg(CFG_MAGIC, 16'($urandom_range(0, 65535)));
        set_reg(CFG_TAG_BEH, 16'h0055);
        set_reg(CFG_TAG_DATA, 16'h0055);
        set_reg(CFG_TAG_ST, 16'h0055);
        set_reg(CFG_TAG_CAP, 16'h0055);
        random_traffic(150);
        wait_drain();

        // Rewrite tags in the middle of a state record
        set_reg(CFG_MAGIC, 16'h0000);
        set_reg(CFG_TAG_BEH, 16'h0010);
        set_reg(CFG_TAG_DATA, 16'h0020);
        set_reg(CFG_TAG_ST, 16'h0030);
        set_reg(CFG_TAG_CAP, 16'h0040);
        put_header(cur_magic, rand_byte(), rand_byte(), {rand_byte(), rand_byte()},
                   rand_byte(), 1'b0);
        add_byte(cur_tag_state); add_byte(8'h00); add_byte(8'h05);
        repeat (2) add_byte(rand_byte());
        post_message(1'b0);
        wait_drain();
        set_reg(CFG_TAG_BEH, {8'h00, cur_tag_state});
        set_reg(CFG_TAG_ST, {8'h00, ~cur_tag_state});
        repeat (3) add_byte(rand_byte());
        post_message(1'b1);
        random_traffic(100);
        wait_drain();

        repeat (2)
        begin
            set_reg(CFG_MAGIC, 16'($urandom_range(0, 65535)));
            set_reg(CFG_TAG_BEH, {8'($urandom), rand_byte()});
            set_reg(CFG_TAG_DATA, {8'($urandom), rand_byte()});
            set_reg(CFG_TAG_ST, {8'($urandom), rand_byte()});
            set_reg(CFG_TAG_CAP, {8'($urandom), rand_byte()});
            random_traffic(100);
            wait_drain();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("** tlv_container_parser_crc8: PASSED **");
        else
            $display("** tlv_container_parser_crc8: FAILED **");
        $finish;
    end

endmodule

FILE: tlv_container_parser_crc8.f
design/tlvp_pkg.sv
design/tlvp_parser.sv
design/tlvp_out_fifo.sv
design/tlv_container_parser_crc8.sv
tb/testbench.sv
